// ===== rtl/core/cv3_pkg.sv =====
// Shared constants, configuration codes and types of the 3x3 streaming convolution core.
`default_nettype none
package cv3_pkg;

  // Default build values
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_PIXEL_BITS  = 16;
  localparam int DEF_WEIGHT_BITS = 8;

  // Kernel geometry
  localparam int KSIZE = 3;
  localparam int NTAPS = KSIZE * KSIZE;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_R01  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_R2   = 2'd3;

  // Register widths fixed by the register map
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;

  // Reset values
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd1024;

  // Smallest legal frame side
  localparam int MIN_SIDE = 3;

  // Position flags of one item, decided when it is accepted
  typedef struct packed {
    logic produce;     // row and column both at least 2
    logic frame_last;  // last pixel of the frame
  } pos_flags_t;

endpackage
`default_nettype wire

// ===== rtl/core/cv3_pix_if.sv =====
// Pixel input channel: valid/ready handshake with one signed pixel per item.
`default_nettype none
interface cv3_pix_if import cv3_pkg::*; #(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cv3_res_if.sv =====
// Result channel: valid/ready handshake with the window sum and the frame-end flag.
`default_nettype none
interface cv3_res_if import cv3_pkg::*; #(
  parameter int SUM_BITS = DEF_PIXEL_BITS + DEF_WEIGHT_BITS + 3
);
  logic                       valid;
  logic                       ready;
  logic signed [SUM_BITS-1:0] sum;
  logic                       frame_last;

  modport source (output valid, output sum, output frame_last, input ready);
  modport sink   (input valid, input sum, input frame_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cv3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cv3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/cv3_cfg_regs.sv =====
// Configuration registers with clamped frame geometry and unpacked kernel weights.
`default_nettype none
module cv3_cfg_regs import cv3_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
  parameter int CFG_DATA_W  = 6 * DEF_WEIGHT_BITS,
  parameter int GEO_W       = 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [CFG_IDX_W-1:0]             cfg_index,
  input  wire logic [CFG_DATA_W-1:0]            cfg_data,
  output logic      [GEO_W-1:0]                 width_eff,
  output logic      [HEIGHT_REG_W-1:0]          height_eff,
  output logic      [NTAPS-1:0][WEIGHT_BITS-1:0] weights
);

  localparam int W01_W = 6 * WEIGHT_BITS;
  localparam int W2_W  = 3 * WEIGHT_BITS;

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [W01_W-1:0]        w01_r;
  logic [W2_W-1:0]         w2_r;
  logic [GEO_W-1:0]        width_ext;

  // Register writes, each truncated to its own width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      w01_r    <= '0;
      w2_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[HEIGHT_REG_W-1:0];
        CFG_WEIGHTS_R01:  w01_r    <= cfg_data[W01_W-1:0];
        CFG_WEIGHTS_R2:   w2_r     <= cfg_data[W2_W-1:0];
        default: ;
      endcase
    end
  end

  // Width clamps to [3, MAX_WIDTH], height clamps below at 3
  assign width_ext = GEO_W'(width_r);

  always_comb begin
    if (width_ext < GEO_W'(MIN_SIDE)) begin
      width_eff = GEO_W'(MIN_SIDE);
    end else if (width_ext > GEO_W'(MAX_WIDTH)) begin
      width_eff = GEO_W'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    if (height_r < HEIGHT_REG_W'(MIN_SIDE)) begin
      height_eff = HEIGHT_REG_W'(MIN_SIDE);
    end else begin
      height_eff = height_r;
    end
  end

  // Row-major weights, weight 0 in the lowest field
  assign weights = {w2_r, w01_r};

endmodule
`default_nettype wire

// ===== rtl/core/cv3_raster_ctr.sv =====
// Raster position counters: line-store address and result/frame-end flags per item.
`default_nettype none
module cv3_raster_ctr import cv3_pkg::*; #(
  parameter int COL_W     = 10,
  parameter int GEO_W     = 12
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    step,
  input  wire logic [GEO_W-1:0]        width_eff,
  input  wire logic [HEIGHT_REG_W-1:0] height_eff,
  output logic      [COL_W-1:0]        col,
  output pos_flags_t                   flags
);

  logic [COL_W-1:0]        col_r, col_nxt;
  logic [HEIGHT_REG_W-1:0] row_r, row_nxt;
  logic [GEO_W:0]          col_inc;
  logic [HEIGHT_REG_W:0]   row_inc;
  logic                    last_col, last_row;

  // End-of-row and end-of-frame tests (also catch a position past the end)
  assign col_inc  = (GEO_W+1)'(col_r) + (GEO_W+1)'(1);
  assign row_inc  = (HEIGHT_REG_W+1)'(row_r) + (HEIGHT_REG_W+1)'(1);
  assign last_col = (col_inc >= {1'b0, width_eff});
  assign last_row = (row_inc >= {1'b0, height_eff});

  assign col              = col_r;
  assign flags.produce    = (row_r >= HEIGHT_REG_W'(2)) && (col_r >= COL_W'(2));
  assign flags.frame_last = last_col && last_row;

  // Next position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_inc[HEIGHT_REG_W-1:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (step) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cv3_mac.sv =====
// Nine products into a product register, then an adder tree into the result register.
`default_nettype none
module cv3_mac import cv3_pkg::*; #(
  parameter int PIXEL_BITS  = DEF_PIXEL_BITS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
  parameter int SUM_BITS    = DEF_PIXEL_BITS + DEF_WEIGHT_BITS + 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              take,
  input  wire logic                              take_last,
  input  wire logic [NTAPS-1:0][PIXEL_BITS-1:0]  taps,
  input  wire logic [NTAPS-1:0][WEIGHT_BITS-1:0] weights,
  output logic                                   can_take,
  cv3_res_if.source                              res
);

  localparam int PROD_W = PIXEL_BITS + WEIGHT_BITS;

  logic signed [PROD_W-1:0]   prod_r [NTAPS];
  logic                       prod_v_r, prod_v_nxt;
  logic                       prod_last_r;
  logic signed [SUM_BITS-1:0] sum_nxt, sum_r;
  logic                       out_v_r, out_v_nxt;
  logic                       out_last_r;
  logic                       out_free, adv_prod;

  // Stall chain: result register, then product register
  assign out_free = !out_v_r || res.ready;
  assign adv_prod = prod_v_r && out_free;
  assign can_take = !prod_v_r || out_free;

  // Product stage
  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < NTAPS; k++) begin
        prod_r[k] <= $signed(taps[k]) * $signed(weights[k]);
      end
      prod_last_r <= take_last;
    end
  end

  // Adder tree over the nine products
  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < NTAPS; k++) begin
      sum_nxt = sum_nxt + SUM_BITS'(prod_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv_prod) begin
      sum_r      <= sum_nxt;
      out_last_r <= prod_last_r;
    end
  end

  // Valid bits
  always_comb begin
    prod_v_nxt = prod_v_r;
    if (take) begin
      prod_v_nxt = 1'b1;
    end else if (adv_prod) begin
      prod_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (adv_prod) begin
      out_v_nxt = 1'b1;
    end else if (res.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      prod_v_r <= prod_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  assign res.valid      = out_v_r;
  assign res.sum        = sum_r;
  assign res.frame_last = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/core/conv2d_3x3_valid_stream_core.sv =====
// Top level of the streaming 3x3 valid-mode convolution core.
// Pixels enter on in_pix in raster order, one item per valid/ready handshake.
// Results leave on out_res: one item per pixel whose row and column are both
// at least 2, carrying the signed 3x3 weighted sum of the window that ends at
// that pixel, with frame_last set on the final result of the frame.
// Registers are written through cfg_we/cfg_index/cfg_data while no item is
// in flight: 0 image width, 1 image height, 2 weights of kernel rows 0 and 1,
// 3 weights of kernel row 2.
// Throughput is one pixel per clock while out_res is not stalled; the line
// stores are one RAM with a registered read issued as a pixel is accepted,
// written back as it leaves stage B, so read and write ports are each used
// once per item. The accepting edge loads stage B and issues the line-store
// read; the item then passes through the product register and the result
// register (adder tree) before out_res.valid rises.
// When the receiver stalls, the result register holds and stages behind it
// keep filling until each is occupied; in_pix.ready falls only then.
// Reset clears the position counters, window, valid bits and registers
// (width 1024, height 1024, zero weights); line-store contents are left as
// they are, and what is read of them in rows 0 and 1 reaches no result.
`default_nettype none
module conv2d_3x3_valid_stream_core import cv3_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS  = DEF_PIXEL_BITS,
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
  parameter int SUM_BITS    = PIXEL_BITS + WEIGHT_BITS + 3,
  parameter int CFG_DATA_W  = (6 * WEIGHT_BITS > HEIGHT_REG_W) ? 6 * WEIGHT_BITS
                                                               : HEIGHT_REG_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  cv3_pix_if.sink                    in_pix,
  cv3_res_if.source                  out_res
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int GEO_W = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_W) ? $clog2(MAX_WIDTH + 1)
                                                               : WIDTH_REG_W;
  localparam int LS_W  = 2 * PIXEL_BITS;

  logic [GEO_W-1:0]                  width_eff;
  logic [HEIGHT_REG_W-1:0]           height_eff;
  logic [NTAPS-1:0][WEIGHT_BITS-1:0] weights;
  logic [COL_W-1:0]                  col;
  pos_flags_t                        flags;

  logic                  accept, adv_b, mac_can_take, mac_take;
  logic                  b_v_r, b_v_nxt;
  logic [PIXEL_BITS-1:0] b_pix_r;
  logic [COL_W-1:0]      b_col_r;
  pos_flags_t            b_flags_r;
  logic [LS_W-1:0]       ls_rdata;
  logic [PIXEL_BITS-1:0] col_upper, col_lower;

  logic [2*KSIZE-1:0][PIXEL_BITS-1:0] win_r;
  logic [NTAPS-1:0][PIXEL_BITS-1:0]   taps;

  cv3_cfg_regs #(
    .MAX_WIDTH   (MAX_WIDTH),
    .WEIGHT_BITS (WEIGHT_BITS),
    .CFG_DATA_W  (CFG_DATA_W),
    .GEO_W       (GEO_W)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .weights    (weights)
  );

  cv3_raster_ctr #(
    .COL_W     (COL_W),
    .GEO_W     (GEO_W)
  ) u_ctr (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (accept),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .col        (col),
    .flags      (flags)
  );

  // Handshake: stage B holds one accepted item while its line-store read lands
  assign adv_b        = b_v_r && (mac_can_take || !b_flags_r.produce);
  assign in_pix.ready = !b_v_r || adv_b;
  assign accept       = in_pix.valid && in_pix.ready;
  assign mac_take     = adv_b && b_flags_r.produce;

  // Line stores: upper row in the high half, lower row in the low half
  cv3_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W)
  ) u_line_store (
    .clk   (clk),
    .we    (adv_b),
    .waddr (b_col_r),
    .wdata ({col_lower, b_pix_r}),
    .re    (accept),
    .raddr (col),
    .rdata (ls_rdata)
  );

  assign col_upper = ls_rdata[LS_W-1:PIXEL_BITS];
  assign col_lower = ls_rdata[PIXEL_BITS-1:0];

  // Stage B registers
  always_ff @(posedge clk) begin
    if (accept) begin
      b_pix_r   <= in_pix.pixel;
      b_col_r   <= col;
      b_flags_r <= flags;
    end
  end

  always_comb begin
    b_v_nxt = b_v_r;
    if (accept) begin
      b_v_nxt = 1'b1;
    end else if (adv_b) begin
      b_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= b_v_nxt;
    end
  end

  // Window: two older columns per row, shifted as each item leaves stage B
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (adv_b) begin
      win_r[0] <= win_r[1];
      win_r[1] <= col_upper;
      win_r[2] <= win_r[3];
      win_r[3] <= col_lower;
      win_r[4] <= win_r[5];
      win_r[5] <= b_pix_r;
    end
  end

  // Taps in kernel order: per row, column c-2, c-1, then the new column
  assign taps = {b_pix_r,   win_r[5], win_r[4],
                 col_lower, win_r[3], win_r[2],
                 col_upper, win_r[1], win_r[0]};

  cv3_mac #(
    .PIXEL_BITS  (PIXEL_BITS),
    .WEIGHT_BITS (WEIGHT_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (mac_take),
    .take_last (b_flags_r.frame_last),
    .taps      (taps),
    .weights   (weights),
    .can_take  (mac_can_take),
    .res       (out_res)
  );

endmodule
`default_nettype wire
